>>> rtl/min_cost_max_flow_assert.svh
// Assertion macros for the min-cost max-flow engine.
// Included by the modules that check their own control logic; needs nothing else.
`ifndef MIN_COST_MAX_FLOW_ASSERT_SVH
`define MIN_COST_MAX_FLOW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCMF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mcmf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mcmf: next-cycle check failed");

`endif

>>> rtl/mcmf_pkg.sv
// Shared types and codes of the min-cost max-flow engine.
// Used by every module of the block; depends on nothing.
package mcmf_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_SOLVED = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_R1,
    ST_ADD_W1,
    ST_ADD_R2,
    ST_ADD_W2,
    ST_INIT,
    ST_POP,
    ST_POP2,
    ST_XLD,
    ST_ARC,
    ST_ARC2,
    ST_REL,
    ST_CHK,
    ST_CHK2,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_WEND,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic st_we;
    logic res_we;
  } arc_ctl_t;

  typedef struct packed {
    logic rec_we;
    logic head_we;
    logic fifo_we;
  } node_ctl_t;

endpackage

>>> rtl/mcmf_arc_store.sv
// Arc table of the min-cost max-flow engine: static arc fields and residuals.
// Two single-port-write memories with registered reads; uses mcmf_pkg.
module mcmf_arc_store #(
  parameter int ARCS  = 512,
  parameter int ST_W  = 39,
  parameter int RES_W = 16
) (
  input  logic                      clk_i,
  input  mcmf_pkg::arc_ctl_t        ctl_i,
  input  logic [$clog2(ARCS)-1:0]   st_waddr_i,
  input  logic [ST_W-1:0]           st_wdata_i,
  input  logic [$clog2(ARCS)-1:0]   st_raddr_i,
  output logic [ST_W-1:0]           st_rdata_o,
  input  logic [$clog2(ARCS)-1:0]   res_waddr_i,
  input  logic [RES_W-1:0]          res_wdata_i,
  input  logic [$clog2(ARCS)-1:0]   res_raddr_i,
  output logic [RES_W-1:0]          res_rdata_o
);

  logic [ST_W-1:0]  st_mem  [ARCS];
  logic [RES_W-1:0] res_mem [ARCS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.st_we) begin
      st_mem[st_waddr_i] <= st_wdata_i;
    end
    st_rdata_o <= st_mem[st_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_we) begin
      res_mem[res_waddr_i] <= res_wdata_i;
    end
    res_rdata_o <= res_mem[res_raddr_i];
  end

endmodule

>>> rtl/mcmf_node_store.sv
// Per-node storage of the min-cost max-flow engine: search records,
// adjacency list heads and the search queue. Uses mcmf_pkg.
module mcmf_node_store #(
  parameter int NODES  = 64,
  parameter int REC_W  = 40,
  parameter int HEAD_W = 10
) (
  input  logic                       clk_i,
  input  mcmf_pkg::node_ctl_t        ctl_i,
  input  logic [$clog2(NODES)-1:0]   rec_waddr_i,
  input  logic [REC_W-1:0]           rec_wdata_i,
  input  logic [$clog2(NODES)-1:0]   rec_raddr_i,
  output logic [REC_W-1:0]           rec_rdata_o,
  input  logic [$clog2(NODES)-1:0]   head_waddr_i,
  input  logic [HEAD_W-1:0]          head_wdata_i,
  input  logic [$clog2(NODES)-1:0]   head_raddr_i,
  output logic [HEAD_W-1:0]          head_rdata_o,
  input  logic [$clog2(NODES)-1:0]   fifo_waddr_i,
  input  logic [$clog2(NODES)-1:0]   fifo_wdata_i,
  input  logic [$clog2(NODES)-1:0]   fifo_raddr_i,
  output logic [$clog2(NODES)-1:0]   fifo_rdata_o
);

  logic [REC_W-1:0]         rec_mem  [NODES];
  logic [HEAD_W-1:0]        head_mem [NODES];
  logic [$clog2(NODES)-1:0] fifo_mem [NODES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.rec_we) begin
      rec_mem[rec_waddr_i] <= rec_wdata_i;
    end
    rec_rdata_o <= rec_mem[rec_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.head_we) begin
      head_mem[head_waddr_i] <= head_wdata_i;
    end
    head_rdata_o <= head_mem[head_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fifo_we) begin
      fifo_mem[fifo_waddr_i] <= fifo_wdata_i;
    end
    fifo_rdata_o <= fifo_mem[fifo_raddr_i];
  end

endmodule

>>> rtl/min_cost_max_flow.sv
// Min-cost max-flow engine: sequencer and datapath over the arc and node stores.
// Uses mcmf_pkg, mcmf_arc_store, mcmf_node_store and min_cost_max_flow_assert.svh.
//
// A command is taken when start is high and busy is low; its single result is
// shown for one cycle with done_o high, and the receiver cannot stall it. Clear,
// unused commands, a rejected solve and an add to a full table go straight to
// the done state; an add edge steps through ST_ADD_R1/W1/R2/W2. A solve runs one
// sequencer over memories with one write and one registered read port each: each
// search dequeues nodes and scans their arcs, checking each arc with residual for
// relaxation, then each found path is walked back once to find the bottleneck and
// once to augment, and a serial multiply of bottleneck by path cost feeds the cost
// total. Each arc and node memory serves one read per cycle. No clearing pass follows reset.
`include "min_cost_max_flow_assert.svh"

module min_cost_max_flow #(
  parameter int NODES     = 64,
  parameter int ARCS      = 512,
  parameter int CAP_BITS  = 16,
  parameter int COST_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [5:0]         from_node_i,
  input  logic [5:0]         to_node_i,
  input  logic [15:0]        capacity_i,
  input  logic signed [15:0] edge_cost_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [31:0]        total_flow_o,
  output logic signed [47:0] total_cost_o
);

  localparam int NW    = $clog2(NODES);
  localparam int AIW   = $clog2(ARCS);
  localparam int AW    = $clog2(ARCS + 1);
  localparam int HW    = $clog2(NODES + 1);
  localparam int UW    = $clog2(NODES + 1);
  localparam int CW    = COST_BITS + 1;
  localparam int CB    = (COST_BITS < 16) ? COST_BITS : 16;
  localparam int CAPIN = (CAP_BITS < 16) ? CAP_BITS : 16;
  localparam int DW    = COST_BITS + 1 + NW;
  localparam int RW    = HW + AW + DW;
  localparam int STW   = NW + NW + CW + AW;
  localparam int PW    = DW + CAP_BITS;
  localparam int SW    = ((PW > 48) ? PW : 48) + 2;
  localparam int MCW   = $clog2(CAP_BITS + 1);
  localparam logic [AW-1:0] NIL = AW'(ARCS);
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< 47) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = SW'(-(64'sd1 <<< 47));

  function automatic logic [NW-1:0] wrap_node(input logic [5:0] v);
    int r;
    r = int'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (NODES << k)) begin
        r = r - (NODES << k);
      end
    end
    return NW'(r);
  endfunction

  mcmf_pkg::state_e state_q, state_d;

  logic [NW-1:0]          u_q, w_q, x_q, y_q, v_q;
  logic [CAP_BITS-1:0]    cap_q, neck_q, mul_q;
  logic signed [CW-1:0]   cost_q;
  logic [AW-1:0]          a_q, cur_q, count_q;
  logic signed [DW-1:0]   dist_x_q, nd_q, dist_dst_q;
  logic [HW-1:0]          hops_x_q;
  logic [NW-1:0]          rd_q, wr_q;
  logic [UW-1:0]          used_q, steps_q;
  logic [NODES-1:0]       reached_q, inq_q, head_vld_q;
  logic [PW-1:0]          prod_q;
  logic [MCW-1:0]         mcnt_q;
  logic [1:0]             status_q;
  logic [31:0]            flow_q;
  logic signed [47:0]     acc_q;

  mcmf_pkg::arc_ctl_t  arc_ctl;
  mcmf_pkg::node_ctl_t node_ctl;
  logic [AIW-1:0] st_waddr, st_raddr, res_waddr, res_raddr;
  logic [STW-1:0] st_wdata, st_rdata;
  logic [CAP_BITS-1:0] res_wdata, res_rdata;
  logic [NW-1:0]  rec_waddr, rec_raddr, head_waddr, head_raddr;
  logic [NW-1:0]  fifo_waddr, fifo_wdata, fifo_raddr, fifo_rdata;
  logic [RW-1:0]  rec_wdata, rec_rdata;
  logic [AW-1:0]  head_wdata, head_rdata;

  logic [NW-1:0]  un, wn;
  logic           accept, full;
  logic signed [CW-1:0] cost_in;
  logic [AW-1:0]  link1, link2;
  logic [AW-1:0]  st_link, rec_pred;
  logic signed [CW-1:0] st_cost;
  logic [NW-1:0]  st_head, st_tail;
  logic signed [DW-1:0] rec_dist, nd_w;
  logic [HW:0]    hop_nx;
  logic           hop_fail, relax, push;
  logic [NW-1:0]  wr_nx;
  logic [DW-1:0]  mag;
  logic signed [SW-1:0] acc_x, prod_x, sum_w;
  logic signed [47:0]   acc_sat;
  logic [32:0]    fsum;
  logic [AW:0]    need;

  assign accept   = start && !busy;
  assign busy     = (state_q != mcmf_pkg::ST_IDLE);
  assign done_o   = (state_q == mcmf_pkg::ST_DONE);
  assign status_o = status_q;
  assign total_flow_o = flow_q;
  assign total_cost_o = acc_q;

  assign un      = wrap_node(from_node_i);
  assign wn      = wrap_node(to_node_i);
  assign cost_in = CW'($signed(edge_cost_i[CB-1:0]));
  assign need    = {1'b0, count_q} + (AW + 1)'(2);
  assign full    = need > (AW + 1)'(ARCS);

  assign st_link  = st_rdata[AW-1:0];
  assign st_cost  = $signed(st_rdata[AW+CW-1:AW]);
  assign st_head  = st_rdata[AW+CW+NW-1:AW+CW];
  assign st_tail  = st_rdata[STW-1:AW+CW+NW];
  assign rec_dist = $signed(rec_rdata[DW-1:0]);
  assign rec_pred = rec_rdata[DW+AW-1:DW];

  assign link1 = head_vld_q[u_q] ? head_rdata : NIL;
  assign link2 = head_vld_q[w_q] ? head_rdata : NIL;
  assign nd_w  = dist_x_q + DW'(st_cost);

  assign hop_nx   = {1'b0, hops_x_q} + (HW + 1)'(1);
  assign hop_fail = hop_nx >= (HW + 1)'(NODES);
  assign relax    = !reached_q[y_q] || (nd_q < rec_dist);
  assign push     = !inq_q[y_q] && (used_q < UW'(NODES));
  assign wr_nx    = (wr_q == NW'(NODES - 1)) ? '0 : wr_q + NW'(1);

  assign mag    = dist_dst_q[DW-1] ? DW'(-dist_dst_q) : DW'(dist_dst_q);
  assign acc_x  = SW'(acc_q);
  assign prod_x = SW'(prod_q);
  assign sum_w  = dist_dst_q[DW-1] ? (acc_x - prod_x) : (acc_x + prod_x);
  assign acc_sat = (sum_w > CMAX) ? 48'(CMAX) :
                   (sum_w < CMIN) ? 48'(CMIN) : sum_w[47:0];
  assign fsum   = {1'b0, flow_q} + 33'(neck_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcmf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mcmf_pkg::cmd_e'(command_i))
            mcmf_pkg::CMD_ADD:   state_d = full ? mcmf_pkg::ST_DONE : mcmf_pkg::ST_ADD_R1;
            mcmf_pkg::CMD_SOLVE: state_d = (un == wn) ? mcmf_pkg::ST_DONE : mcmf_pkg::ST_INIT;
            mcmf_pkg::CMD_CLEAR: state_d = mcmf_pkg::ST_DONE;
            mcmf_pkg::CMD_NONE:  state_d = mcmf_pkg::ST_DONE;
          endcase
        end
      end
      mcmf_pkg::ST_ADD_R1: state_d = mcmf_pkg::ST_ADD_W1;
      mcmf_pkg::ST_ADD_W1: state_d = mcmf_pkg::ST_ADD_R2;
      mcmf_pkg::ST_ADD_R2: state_d = mcmf_pkg::ST_ADD_W2;
      mcmf_pkg::ST_ADD_W2: state_d = mcmf_pkg::ST_DONE;
      mcmf_pkg::ST_INIT:   state_d = mcmf_pkg::ST_POP;
      mcmf_pkg::ST_POP:    state_d = (used_q == '0) ? mcmf_pkg::ST_CHK : mcmf_pkg::ST_POP2;
      mcmf_pkg::ST_POP2:   state_d = mcmf_pkg::ST_XLD;
      mcmf_pkg::ST_XLD:    state_d = mcmf_pkg::ST_ARC;
      mcmf_pkg::ST_ARC:    state_d = (a_q >= count_q) ? mcmf_pkg::ST_POP : mcmf_pkg::ST_ARC2;
      mcmf_pkg::ST_ARC2:   state_d = (res_rdata == '0) ? mcmf_pkg::ST_ARC : mcmf_pkg::ST_REL;
      mcmf_pkg::ST_REL:    state_d = (relax && hop_fail) ? mcmf_pkg::ST_DONE : mcmf_pkg::ST_ARC;
      mcmf_pkg::ST_CHK:    state_d = reached_q[w_q] ? mcmf_pkg::ST_CHK2 : mcmf_pkg::ST_DONE;
      mcmf_pkg::ST_CHK2:   state_d = mcmf_pkg::ST_W1;
      mcmf_pkg::ST_W1:     state_d = (v_q == u_q) ? mcmf_pkg::ST_WEND : mcmf_pkg::ST_W2;
      mcmf_pkg::ST_W2: begin
        if (rec_pred >= count_q || steps_q >= UW'(NODES)) begin
          state_d = mcmf_pkg::ST_DONE;
        end else begin
          state_d = mcmf_pkg::ST_W3;
        end
      end
      mcmf_pkg::ST_W3:     state_d = mcmf_pkg::ST_W1;
      mcmf_pkg::ST_WEND:   state_d = (neck_q == '0) ? mcmf_pkg::ST_DONE : mcmf_pkg::ST_A1;
      mcmf_pkg::ST_A1:     state_d = (v_q == u_q) ? mcmf_pkg::ST_MUL : mcmf_pkg::ST_A2;
      mcmf_pkg::ST_A2:     state_d = mcmf_pkg::ST_A3;
      mcmf_pkg::ST_A3:     state_d = mcmf_pkg::ST_A4;
      mcmf_pkg::ST_A4:     state_d = mcmf_pkg::ST_A1;
      mcmf_pkg::ST_MUL:    state_d = (mcnt_q == '0) ? mcmf_pkg::ST_ACC : mcmf_pkg::ST_MUL;
      mcmf_pkg::ST_ACC:    state_d = mcmf_pkg::ST_INIT;
      mcmf_pkg::ST_DONE:   state_d = mcmf_pkg::ST_IDLE;
      default:             state_d = mcmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    arc_ctl    = '0;
    node_ctl   = '0;
    st_waddr   = count_q[AIW-1:0];
    st_wdata   = {u_q, w_q, cost_q, link1};
    st_raddr   = a_q[AIW-1:0];
    res_waddr  = count_q[AIW-1:0];
    res_wdata  = cap_q;
    res_raddr  = a_q[AIW-1:0];
    rec_waddr  = y_q;
    rec_wdata  = {HW'(hop_nx), cur_q, nd_q};
    rec_raddr  = v_q;
    head_waddr = u_q;
    head_wdata = count_q;
    head_raddr = u_q;
    fifo_waddr = wr_q;
    fifo_wdata = y_q;
    fifo_raddr = rd_q;
    unique case (state_q)
      mcmf_pkg::ST_ADD_W1: begin
        arc_ctl.st_we    = 1'b1;
        arc_ctl.res_we   = 1'b1;
        node_ctl.head_we = 1'b1;
      end
      mcmf_pkg::ST_ADD_R2: head_raddr = w_q;
      mcmf_pkg::ST_ADD_W2: begin
        arc_ctl.st_we    = 1'b1;
        arc_ctl.res_we   = 1'b1;
        node_ctl.head_we = 1'b1;
        st_waddr   = count_q[AIW-1:0] + AIW'(1);
        st_wdata   = {w_q, u_q, -cost_q, link2};
        res_waddr  = count_q[AIW-1:0] + AIW'(1);
        res_wdata  = '0;
        head_waddr = w_q;
        head_wdata = count_q + AW'(1);
      end
      mcmf_pkg::ST_INIT: begin
        node_ctl.rec_we  = 1'b1;
        node_ctl.fifo_we = 1'b1;
        rec_waddr  = u_q;
        rec_wdata  = {HW'(0), NIL, DW'(0)};
        fifo_waddr = '0;
        fifo_wdata = u_q;
      end
      mcmf_pkg::ST_POP2: begin
        rec_raddr  = fifo_rdata;
        head_raddr = fifo_rdata;
      end
      mcmf_pkg::ST_ARC2: rec_raddr = st_head;
      mcmf_pkg::ST_REL: begin
        node_ctl.rec_we  = relax && !hop_fail;
        node_ctl.fifo_we = relax && !hop_fail && push;
      end
      mcmf_pkg::ST_CHK: rec_raddr = w_q;
      mcmf_pkg::ST_W2: begin
        st_raddr  = rec_pred[AIW-1:0];
        res_raddr = rec_pred[AIW-1:0];
      end
      mcmf_pkg::ST_A2: begin
        st_raddr  = rec_pred[AIW-1:0];
        res_raddr = rec_pred[AIW-1:0];
      end
      mcmf_pkg::ST_A3: begin
        arc_ctl.res_we = 1'b1;
        res_waddr = cur_q[AIW-1:0];
        res_wdata = res_rdata - neck_q;
        res_raddr = cur_q[AIW-1:0] ^ AIW'(1);
      end
      mcmf_pkg::ST_A4: begin
        arc_ctl.res_we = 1'b1;
        res_waddr = cur_q[AIW-1:0] ^ AIW'(1);
        res_wdata = res_rdata + neck_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mcmf_pkg::ST_IDLE;
      u_q        <= '0;
      w_q        <= '0;
      x_q        <= '0;
      y_q        <= '0;
      v_q        <= '0;
      cap_q      <= '0;
      neck_q     <= '0;
      mul_q      <= '0;
      cost_q     <= '0;
      a_q        <= '0;
      cur_q      <= '0;
      count_q    <= '0;
      dist_x_q   <= '0;
      nd_q       <= '0;
      dist_dst_q <= '0;
      hops_x_q   <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      used_q     <= '0;
      steps_q    <= '0;
      reached_q  <= '0;
      inq_q      <= '0;
      head_vld_q <= '0;
      prod_q     <= '0;
      mcnt_q     <= '0;
      status_q   <= mcmf_pkg::STAT_OK;
      flow_q     <= '0;
      acc_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        mcmf_pkg::ST_IDLE: begin
          if (accept) begin
            u_q    <= un;
            w_q    <= wn;
            cap_q  <= CAP_BITS'(capacity_i[CAPIN-1:0]);
            cost_q <= cost_in;
            flow_q <= '0;
            acc_q  <= '0;
            unique case (mcmf_pkg::cmd_e'(command_i))
              mcmf_pkg::CMD_CLEAR: begin
                status_q   <= mcmf_pkg::STAT_OK;
                head_vld_q <= '0;
                count_q    <= '0;
              end
              mcmf_pkg::CMD_ADD: begin
                status_q <= full ? mcmf_pkg::STAT_FULL : mcmf_pkg::STAT_OK;
              end
              mcmf_pkg::CMD_SOLVE: begin
                status_q <= (un == wn) ? mcmf_pkg::STAT_REJECT : mcmf_pkg::STAT_SOLVED;
              end
              mcmf_pkg::CMD_NONE: status_q <= mcmf_pkg::STAT_OK;
            endcase
          end
        end
        mcmf_pkg::ST_ADD_W1: head_vld_q[u_q] <= 1'b1;
        mcmf_pkg::ST_ADD_W2: begin
          head_vld_q[w_q] <= 1'b1;
          count_q <= count_q + AW'(2);
        end
        mcmf_pkg::ST_INIT: begin
          reached_q      <= NODES'(1) << u_q;
          inq_q          <= NODES'(1) << u_q;
          rd_q           <= '0;
          wr_q           <= NW'(1);
          used_q         <= UW'(1);
        end
        mcmf_pkg::ST_POP: begin
          if (used_q != '0) begin
            rd_q   <= (rd_q == NW'(NODES - 1)) ? '0 : rd_q + NW'(1);
            used_q <= used_q - UW'(1);
          end
        end
        mcmf_pkg::ST_POP2: begin
          x_q <= fifo_rdata;
          inq_q[fifo_rdata] <= 1'b0;
        end
        mcmf_pkg::ST_XLD: begin
          dist_x_q <= rec_dist;
          hops_x_q <= rec_rdata[RW-1:DW+AW];
          a_q      <= head_vld_q[x_q] ? head_rdata : NIL;
        end
        mcmf_pkg::ST_ARC2: begin
          cur_q <= a_q;
          a_q   <= st_link;
          y_q   <= st_head;
          nd_q  <= nd_w;
        end
        mcmf_pkg::ST_REL: begin
          if (relax && !hop_fail) begin
            reached_q[y_q] <= 1'b1;
            if (y_q == x_q) begin
              dist_x_q <= nd_q;
              hops_x_q <= HW'(hop_nx);
            end
            if (push) begin
              inq_q[y_q] <= 1'b1;
              wr_q       <= wr_nx;
              used_q     <= used_q + UW'(1);
            end
          end
        end
        mcmf_pkg::ST_CHK2: begin
          dist_dst_q <= rec_dist;
          v_q        <= w_q;
          steps_q    <= '0;
          neck_q     <= '1;
        end
        mcmf_pkg::ST_W2: cur_q <= rec_pred;
        mcmf_pkg::ST_W3: begin
          if (res_rdata < neck_q) begin
            neck_q <= res_rdata;
          end
          v_q     <= st_tail;
          steps_q <= steps_q + UW'(1);
        end
        mcmf_pkg::ST_WEND: begin
          v_q    <= w_q;
          prod_q <= '0;
          mul_q  <= neck_q;
          mcnt_q <= MCW'(CAP_BITS - 1);
        end
        mcmf_pkg::ST_A2: cur_q <= rec_pred;
        mcmf_pkg::ST_A3: v_q <= st_tail;
        mcmf_pkg::ST_MUL: begin
          prod_q <= (prod_q << 1) + (mul_q[CAP_BITS-1] ? PW'(mag) : PW'(0));
          mul_q  <= mul_q << 1;
          mcnt_q <= mcnt_q - MCW'(1);
        end
        mcmf_pkg::ST_ACC: begin
          acc_q  <= acc_sat;
          flow_q <= fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  mcmf_arc_store #(
    .ARCS  (ARCS),
    .ST_W  (STW),
    .RES_W (CAP_BITS)
  ) u_arc (
    .clk_i       (clk_i),
    .ctl_i       (arc_ctl),
    .st_waddr_i  (st_waddr),
    .st_wdata_i  (st_wdata),
    .st_raddr_i  (st_raddr),
    .st_rdata_o  (st_rdata),
    .res_waddr_i (res_waddr),
    .res_wdata_i (res_wdata),
    .res_raddr_i (res_raddr),
    .res_rdata_o (res_rdata)
  );

  mcmf_node_store #(
    .NODES  (NODES),
    .REC_W  (RW),
    .HEAD_W (AW)
  ) u_node (
    .clk_i        (clk_i),
    .ctl_i        (node_ctl),
    .rec_waddr_i  (rec_waddr),
    .rec_wdata_i  (rec_wdata),
    .rec_raddr_i  (rec_raddr),
    .rec_rdata_o  (rec_rdata),
    .head_waddr_i (head_waddr),
    .head_wdata_i (head_wdata),
    .head_raddr_i (head_raddr),
    .head_rdata_o (head_rdata),
    .fifo_waddr_i (fifo_waddr),
    .fifo_wdata_i (fifo_wdata),
    .fifo_raddr_i (fifo_raddr),
    .fifo_rdata_o (fifo_rdata)
  );

  `MCMF_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `MCMF_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, accept, busy)
  `MCMF_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= AW'(ARCS))
  `MCMF_ASSERT_SAME(a_queue_bound, clk_i, rst_ni, busy, used_q <= UW'(NODES))
  `MCMF_ASSERT_SAME(a_reject_zero, clk_i, rst_ni, done_o && status_o != mcmf_pkg::STAT_SOLVED,
                    total_flow_o == 32'd0 && total_cost_o == 48'sd0)

endmodule
